/* sv/psd_pkg.sv */
`timescale 1ns / 1ps
// psd_pkg: widths and sizes shared by the point set diameter core.
// No dependencies.
package psd_pkg;

  localparam int unsigned MAX_POINTS = 128;
  localparam int unsigned ADDR_W     = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W      = $clog2(MAX_POINTS + 1);

  localparam int unsigned COORD_W    = 24;
  localparam int unsigned DIFF_W     = COORD_W + 1;
  localparam int unsigned PROD_W     = 2 * DIFF_W;
  localparam int unsigned SQ_W       = 51;
  localparam int unsigned DIAM_W     = 25;
  localparam int unsigned COUNT_W    = 8;
  localparam int unsigned ENTRY_W    = 2 * COORD_W;

  // highest even bit position of the squared distance, seed of the root search
  localparam int unsigned SQRT_TOP   = ((SQ_W - 1) / 2) * 2;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [SQ_W-1:0]    sq_t;

endpackage

/* sv/point_set_diameter_core.sv */
`timescale 1ns / 1ps
// point_set_diameter_core: running max pairwise squared distance over a point store,
// integer square root on the last point. Depends on psd_pkg.
//
//  channel  | ports                                   | transfer
//  ---------+-----------------------------------------+------------------------------
//  command  | start, busy, point_x_i, point_y_i,      | start high while busy low
//           | is_last_i                               |
//  result   | done_o, diameter_o, point_count_o,      | one cycle with done_o high
//           | overflowed_o                            |
//
//  A point with n points already stored reads the n stored points, one store read per
//  cycle, through a four-stage read/difference/square/compare pipeline. A point that is
//  stored first or dropped on a full store is not scanned. The last point adds the
//  one-bit-pair-per-cycle square root. Reset clears count, max and flags; the store
//  needs no clearing. The receiver cannot stall: done_o is a one-cycle pulse.
module point_set_diameter_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [psd_pkg::COORD_W-1:0] point_x_i,
  input  logic [psd_pkg::COORD_W-1:0] point_y_i,
  input  logic                        is_last_i,
  output logic                        done_o,
  output logic [psd_pkg::DIAM_W-1:0]  diameter_o,
  output logic [psd_pkg::COUNT_W-1:0] point_count_o,
  output logic                        overflowed_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_SQRT
  } state_e;

  localparam int unsigned ADDR_W = psd_pkg::ADDR_W;
  localparam int unsigned CNT_W  = psd_pkg::CNT_W;
  localparam int unsigned SQ_W   = psd_pkg::SQ_W;
  localparam int unsigned DIFF_W = psd_pkg::DIFF_W;
  localparam int unsigned PROD_W = psd_pkg::PROD_W;

  state_e                          state_q;
  logic [CNT_W-1:0]                count_q;
  psd_pkg::sq_t                    max_q;
  logic                            ovf_q;
  logic                            last_q;
  logic [ADDR_W-1:0]               rd_addr_q;
  logic [ADDR_W-1:0]               end_addr_q;
  logic                            v1_q, v2_q, v3_q;
  logic                            done_q;
  logic [psd_pkg::DIAM_W-1:0]      diam_q;
  logic [CNT_W-1:0]                cnt_out_q;
  logic                            ovf_out_q;

  logic [psd_pkg::ENTRY_W-1:0]     mem [psd_pkg::MAX_POINTS];
  logic [psd_pkg::ENTRY_W-1:0]     rd_data_q;
  psd_pkg::coord_t                 x_q, y_q;
  logic [DIFF_W-1:0]               dx_q, dy_q;
  logic [PROD_W-1:0]               sqx_q, sqy_q;
  psd_pkg::sq_t                    rem_q, root_q, bit_q;

  logic                            accept;
  logic                            has_room;
  logic                            wr_en;
  logic signed [DIFF_W-1:0]        dx_s, dy_s;
  logic [DIFF_W-1:0]               dx_mag, dy_mag;
  psd_pkg::sq_t                    sq_sum;
  psd_pkg::sq_t                    max_upd;
  logic [SQ_W:0]                   trial;
  logic                            take;
  psd_pkg::sq_t                    rem_d, root_d;

  assign busy     = (state_q != ST_IDLE);
  assign accept   = start && !busy;
  assign has_room = (count_q < CNT_W'(psd_pkg::MAX_POINTS));
  assign wr_en    = accept && has_room;

  // difference stage, from registered store data
  assign dx_s   = DIFF_W'($signed(x_q)) - DIFF_W'($signed(rd_data_q[psd_pkg::ENTRY_W-1 -:
                  psd_pkg::COORD_W]));
  assign dy_s   = DIFF_W'($signed(y_q)) - DIFF_W'($signed(rd_data_q[psd_pkg::COORD_W-1:0]));
  assign dx_mag = dx_s[DIFF_W-1] ? DIFF_W'(-dx_s) : DIFF_W'(dx_s);
  assign dy_mag = dy_s[DIFF_W-1] ? DIFF_W'(-dy_s) : DIFF_W'(dy_s);

  assign sq_sum  = SQ_W'(sqx_q) + SQ_W'(sqy_q);
  assign max_upd = (v3_q && (sq_sum > max_q)) ? sq_sum : max_q;

  // one bit pair of the root per cycle
  assign trial  = {1'b0, root_q} + {1'b0, bit_q};
  assign take   = ({1'b0, rem_q} >= trial);
  assign rem_d  = take ? SQ_W'({1'b0, rem_q} - trial) : rem_q;
  assign root_d = take ? SQ_W'((root_q >> 1) + bit_q) : (root_q >> 1);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[count_q[ADDR_W-1:0]] <= {point_x_i, point_y_i};
    end
    rd_data_q <= mem[rd_addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q <= point_x_i;
      y_q <= point_y_i;
    end
    dx_q  <= dx_mag;
    dy_q  <= dy_mag;
    sqx_q <= dx_q * dx_q;
    sqy_q <= dy_q * dy_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      count_q    <= '0;
      max_q      <= '0;
      ovf_q      <= 1'b0;
      last_q     <= 1'b0;
      rd_addr_q  <= '0;
      end_addr_q <= '0;
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      v3_q       <= 1'b0;
      done_q     <= 1'b0;
      diam_q     <= '0;
      cnt_out_q  <= '0;
      ovf_out_q  <= 1'b0;
      rem_q      <= '0;
      root_q     <= '0;
      bit_q      <= '0;
    end else begin
      done_q <= 1'b0;
      v1_q   <= (state_q == ST_SCAN);
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      max_q  <= max_upd;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            last_q <= is_last_i;
            if (has_room) begin
              count_q    <= count_q + CNT_W'(1);
              rd_addr_q  <= '0;
              end_addr_q <= ADDR_W'(count_q - CNT_W'(1));
            end else begin
              ovf_q <= 1'b1;
            end
            if (has_room && (count_q != '0)) begin
              state_q <= ST_SCAN;
            end else if (is_last_i) begin
              rem_q   <= max_q;
              root_q  <= '0;
              bit_q   <= SQ_W'(1) << psd_pkg::SQRT_TOP;
              state_q <= ST_SQRT;
            end
          end
        end
        ST_SCAN: begin
          rd_addr_q <= rd_addr_q + ADDR_W'(1);
          if (rd_addr_q == end_addr_q) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!v1_q && !v2_q && !v3_q) begin
            if (last_q) begin
              rem_q   <= max_q;
              root_q  <= '0;
              bit_q   <= SQ_W'(1) << psd_pkg::SQRT_TOP;
              state_q <= ST_SQRT;
            end else begin
              state_q <= ST_IDLE;
            end
          end
        end
        ST_SQRT: begin
          rem_q  <= rem_d;
          root_q <= root_d;
          bit_q  <= bit_q >> 2;
          if (bit_q[0]) begin
            done_q    <= 1'b1;
            diam_q    <= root_d[psd_pkg::DIAM_W-1:0];
            cnt_out_q <= count_q;
            ovf_out_q <= ovf_q;
            count_q   <= '0;
            max_q     <= '0;
            ovf_q     <= 1'b0;
            state_q   <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign done_o        = done_q;
  assign diameter_o    = diam_q;
  assign point_count_o = psd_pkg::COUNT_W'(cnt_out_q);
  assign overflowed_o  = ovf_out_q;

endmodule

/* dv/point_set_diameter_core_test.sv */
`timescale 1ns / 1ps
// point_set_diameter_core_test: sends point sets through the command port and checks
// each diameter, count and overflow flag against a predictor run on every transfer.
// Depends on psd_pkg and point_set_diameter_core.
module point_set_diameter_core_test;

  typedef struct {
    logic [psd_pkg::DIAM_W-1:0]  diameter;
    logic [psd_pkg::COUNT_W-1:0] point_count;
    logic                        overflowed;
  } set_result_t;

  typedef enum int {
    SPREAD_WIDE,
    SPREAD_CLUSTER,
    SPREAD_CORNERS
  } spread_e;

  logic                         clk_i;
  logic                         rst_ni = 1'b0;
  logic                         start = 1'b0;
  logic                         busy;
  psd_pkg::coord_t              point_x_i = '0;
  psd_pkg::coord_t              point_y_i = '0;
  logic                         is_last_i = 1'b0;
  logic                         done_o;
  logic [psd_pkg::DIAM_W-1:0]   diameter_o;
  logic [psd_pkg::COUNT_W-1:0]  point_count_o;
  logic                         overflowed_o;

  // predictor state
  psd_pkg::coord_t              kept_x [psd_pkg::MAX_POINTS];
  psd_pkg::coord_t              kept_y [psd_pkg::MAX_POINTS];
  int unsigned                  kept_count = 0;
  psd_pkg::sq_t                 widest_sq = '0;
  bit                           dropped = 1'b0;

  set_result_t                  expected_sets[$];
  int unsigned                  mismatch_count = 0;
  int unsigned                  sent_points = 0;
  bit                           gaps_on = 1'b1;
  int unsigned                  gap_pct = 0;

  localparam psd_pkg::coord_t COORD_MIN = 24'h800000;
  localparam psd_pkg::coord_t COORD_MAX = 24'h7FFFFF;

  point_set_diameter_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .point_x_i     (point_x_i),
    .point_y_i     (point_y_i),
    .is_last_i     (is_last_i),
    .done_o        (done_o),
    .diameter_o    (diameter_o),
    .point_count_o (point_count_o),
    .overflowed_o  (overflowed_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10ms;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic logic [psd_pkg::DIAM_W-1:0] floor_root(psd_pkg::sq_t v);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = psd_pkg::DIAM_W; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= 64'(v)) root = trial;
    end
    return root[psd_pkg::DIAM_W-1:0];
  endfunction

  task automatic absorb_point(psd_pkg::coord_t x, psd_pkg::coord_t y, logic last);
    longint       dx;
    longint       dy;
    psd_pkg::sq_t d2;
    set_result_t  r;
    if (kept_count < psd_pkg::MAX_POINTS) begin
      for (int i = 0; i < kept_count; i++) begin
        dx = longint'($signed(x)) - longint'($signed(kept_x[i]));
        dy = longint'($signed(y)) - longint'($signed(kept_y[i]));
        d2 = psd_pkg::sq_t'(dx * dx + dy * dy);
        if (d2 > widest_sq) widest_sq = d2;
      end
      kept_x[kept_count] = x;
      kept_y[kept_count] = y;
      kept_count++;
    end else begin
      dropped = 1'b1;
    end
    if (last) begin
      r.diameter    = floor_root(widest_sq);
      r.point_count = psd_pkg::COUNT_W'(kept_count);
      r.overflowed  = dropped;
      expected_sets.push_back(r);
      kept_count = 0;
      widest_sq  = '0;
      dropped    = 1'b0;
    end
  endtask

  // one command transfer, with an optional idle burst ahead of it
  task automatic send_point(psd_pkg::coord_t x, psd_pkg::coord_t y, logic last);
    if (gaps_on && $urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(19, 1)) @(posedge clk_i);
    end
    start     <= 1'b1;
    point_x_i <= x;
    point_y_i <= y;
    is_last_i <= last;
    do @(posedge clk_i); while (busy !== 1'b0);
    absorb_point(x, y, last);
    sent_points++;
  endtask

  always @(posedge clk_i) begin
    set_result_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (expected_sets.size() == 0) begin
        report_mismatch($sformatf("result with none pending: diameter %0d count %0d ovf %0b",
                                  diameter_o, point_count_o, overflowed_o));
      end else begin
        want = expected_sets.pop_front();
        if (diameter_o !== want.diameter)
          report_mismatch($sformatf("diameter %0d, want %0d", diameter_o, want.diameter));
        if (point_count_o !== want.point_count)
          report_mismatch($sformatf("point_count %0d, want %0d",
                                    point_count_o, want.point_count));
        if (overflowed_o !== want.overflowed)
          report_mismatch($sformatf("overflowed %0b, want %0b",
                                    overflowed_o, want.overflowed));
      end
    end
  end

  function automatic psd_pkg::coord_t corner_coord();
    case ($urandom_range(4))
      0: return COORD_MIN;
      1: return COORD_MAX;
      2: return 24'hFFFFFF;
      3: return 24'h000001;
      default: return '0;
    endcase
  endfunction

  // one set of random content, last point flagged
  task automatic send_set(int unsigned size);
    spread_e         spread;
    psd_pkg::coord_t base_x;
    psd_pkg::coord_t base_y;
    psd_pkg::coord_t x;
    psd_pkg::coord_t y;
    spread = spread_e'($urandom_range(2));
    base_x = psd_pkg::coord_t'($urandom);
    base_y = psd_pkg::coord_t'($urandom);
    case ($urandom_range(2))
      0: gap_pct = 0;
      1: gap_pct = 15;
      default: gap_pct = 50;
    endcase
    for (int unsigned i = 1; i <= size; i++) begin
      case (spread)
        SPREAD_WIDE: begin
          x = psd_pkg::coord_t'($urandom);
          y = psd_pkg::coord_t'($urandom);
        end
        SPREAD_CLUSTER: begin
          x = base_x + psd_pkg::coord_t'($urandom_range(511)) - 24'd256;
          y = base_y + psd_pkg::coord_t'($urandom_range(511)) - 24'd256;
        end
        default: begin
          x = corner_coord();
          y = corner_coord();
        end
      endcase
      send_point(x, y, i == size);
    end
  endtask

  task automatic test_lone_points();
    gap_pct = 30;
    send_point('0, '0, 1'b1);
    send_point(COORD_MIN, COORD_MAX, 1'b1);
  endtask

  task automatic test_extreme_span();
    send_point(COORD_MIN, COORD_MIN, 1'b0);
    send_point(COORD_MAX, COORD_MAX, 1'b1);
    send_point(COORD_MAX, COORD_MIN, 1'b0);
    send_point(COORD_MIN, COORD_MAX, 1'b1);
    send_point(COORD_MIN, '0, 1'b0);
    send_point(COORD_MAX, '0, 1'b1);
    send_point(24'h555555, 24'hAAAAAA, 1'b0);
    send_point(24'hAAAAAA, 24'h555555, 1'b1);
  endtask

  task automatic test_coincident();
    send_point(24'd5, -24'sd7, 1'b0);
    send_point(24'd5, -24'sd7, 1'b0);
    send_point(24'd5, -24'sd7, 1'b1);
  endtask

  // widest pair involves the last point, just wider than the span of the first two
  task automatic test_early_max();
    send_point('0, '0, 1'b0);
    send_point(24'd4096000, '0, 1'b0);
    send_point(24'd10, 24'd10, 1'b0);
    send_point(-24'sd3, 24'd2, 1'b1);
  endtask

  // exactly full, one dropped, several dropped with the flagged point dropped too
  task automatic test_full_store();
    send_set(psd_pkg::MAX_POINTS);
    send_set(psd_pkg::MAX_POINTS + 1);
    send_set(psd_pkg::MAX_POINTS + 4);
  endtask

  task automatic test_random_sets(int unsigned n_points);
    int unsigned stop_at;
    int unsigned roll;
    stop_at = sent_points + n_points;
    while (sent_points < stop_at) begin
      roll = $urandom_range(99);
      if (roll < 70)      send_set($urandom_range(8, 1));
      else if (roll < 95) send_set($urandom_range(40, 9));
      else                send_set($urandom_range(psd_pkg::MAX_POINTS + 2, 41));
    end
  endtask

  initial begin
    int unsigned waited;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_lone_points();
    test_extreme_span();
    test_coincident();
    test_early_max();
    test_full_store();
    test_random_sets(800);
    gaps_on = 1'b0;
    test_random_sets(150);
    start <= 1'b0;

    waited = 0;
    while (expected_sets.size() != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    while (expected_sets.size() != 0) begin
      void'(expected_sets.pop_front());
      report_mismatch("expected result never arrived");
    end
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
sv/psd_pkg.sv
sv/point_set_diameter_core.sv
dv/point_set_diameter_core_test.sv
